@@ src/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and the sequence ROM of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // wait kinds of a sequence step
  localparam logic [1:0] W_NONE  = 2'd0;
  localparam logic [1:0] W_DELAY = 2'd1;
  localparam logic [1:0] W_SCL   = 2'd2;

  // pin actions of a sequence step
  localparam logic [3:0] A_NOP        = 4'd0;
  localparam logic [3:0] A_SDA_REL    = 4'd1;
  localparam logic [3:0] A_SDA_LOW    = 4'd2;
  localparam logic [3:0] A_SCL_LOW    = 4'd3;
  localparam logic [3:0] A_SDA_BIT    = 4'd4;
  localparam logic [3:0] A_SDA_ACK    = 4'd5;
  localparam logic [3:0] A_WR_NEXT    = 4'd6;
  localparam logic [3:0] A_RD_NEXT    = 4'd7;
  localparam logic [3:0] A_ACK_SAMPLE = 4'd8;
  localparam logic [3:0] A_RD_END     = 4'd9;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_START   = 5'd1;
  localparam logic [4:0] PH_STOP    = 5'd6;
  localparam logic [4:0] PH_WRITE   = 5'd11;
  localparam logic [4:0] PH_READ    = 5'd19;
  localparam logic [4:0] PH_WR_LOOP = 5'd11;
  localparam logic [4:0] PH_RD_LOOP = 5'd20;
  localparam logic [4:0] LAST_PHASE = 5'd27;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [1:0]  CFG_HALF_PERIOD   = 2'd0;
  localparam logic [1:0]  CFG_STRETCH_LIMIT = 2'd1;
  localparam logic [15:0] HALF_PERIOD_RST   = 16'd100;
  localparam logic [15:0] STRETCH_LIMIT_RST = 16'd10000;

  typedef struct packed {
    logic [3:0] act;
    logic [1:0] wkind;
    logic       last;
    logic [4:0] loop_to;
  } uop_t;

  typedef struct packed {
    logic       sda_in;
    logic       scl_in;
    logic       ack_to_send;
    logic [7:0] wr_byte;
    logic [2:0] cmd;
  } item_t;

  typedef struct packed {
    logic       stretch_timeout;
    logic       ack_received;
    logic [7:0] rd_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive_low;
    logic       scl_drive_low;
  } res_t;

  function automatic uop_t rom_op(input logic [4:0] ph);
    uop_t op;
    op = '{A_NOP, W_NONE, 1'b1, PH_IDLE};
    case (ph)
      5'd1:  op = '{A_SDA_REL,    W_NONE,  1'b0, PH_IDLE};
      5'd2:  op = '{A_NOP,        W_SCL,   1'b0, PH_IDLE};
      5'd3:  op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd4:  op = '{A_SDA_LOW,    W_DELAY, 1'b0, PH_IDLE};
      5'd5:  op = '{A_SCL_LOW,    W_DELAY, 1'b1, PH_IDLE};
      5'd6:  op = '{A_SCL_LOW,    W_DELAY, 1'b0, PH_IDLE};
      5'd7:  op = '{A_SDA_LOW,    W_DELAY, 1'b0, PH_IDLE};
      5'd8:  op = '{A_NOP,        W_SCL,   1'b0, PH_IDLE};
      5'd9:  op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd10: op = '{A_SDA_REL,    W_DELAY, 1'b1, PH_IDLE};
      5'd11: op = '{A_SDA_BIT,    W_DELAY, 1'b0, PH_IDLE};
      5'd12: op = '{A_NOP,        W_SCL,   1'b0, PH_IDLE};
      5'd13: op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd14: op = '{A_WR_NEXT,    W_NONE,  1'b0, PH_WR_LOOP};
      5'd15: op = '{A_SDA_REL,    W_DELAY, 1'b0, PH_IDLE};
      5'd16: op = '{A_NOP,        W_SCL,   1'b0, PH_IDLE};
      5'd17: op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd18: op = '{A_ACK_SAMPLE, W_DELAY, 1'b1, PH_IDLE};
      5'd19: op = '{A_SDA_REL,    W_NONE,  1'b0, PH_IDLE};
      5'd20: op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd21: op = '{A_NOP,        W_SCL,   1'b0, PH_IDLE};
      5'd22: op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd23: op = '{A_RD_NEXT,    W_NONE,  1'b0, PH_RD_LOOP};
      5'd24: op = '{A_SDA_ACK,    W_DELAY, 1'b0, PH_IDLE};
      5'd25: op = '{A_NOP,        W_SCL,   1'b0, PH_IDLE};
      5'd26: op = '{A_NOP,        W_DELAY, 1'b0, PH_IDLE};
      5'd27: op = '{A_RD_END,     W_NONE,  1'b1, PH_IDLE};
      default: op = '{A_NOP, W_NONE, 1'b1, PH_IDLE};
    endcase
    return op;
  endfunction

  function automatic logic [4:0] cmd_entry(input logic [2:0] cmd);
    logic [4:0] ph;
    case (cmd)
      CMD_START: ph = PH_START;
      CMD_STOP:  ph = PH_STOP;
      CMD_WRITE: ph = PH_WRITE;
      CMD_READ:  ph = PH_READ;
      default:   ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

@@ src/i2cm_step.sv @@
// ----------------------------------------------------------------------------
// i2cm_step
// Sequencer state and the per-tick update: one step of the pin sequence ROM.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  i2cm_pkg::item_t  item,
  input  logic [15:0]      half_period,
  input  logic [15:0]      stretch_limit,
  output i2cm_pkg::res_t   res
);

  logic [4:0]  phase;
  logic [2:0]  active_command;
  logic [3:0]  bit_counter;
  logic [15:0] delay_counter;
  logic [15:0] stretch_counter;
  logic [7:0]  shift_byte;
  logic        ack_flag;
  logic        scl_low_reg;
  logic        sda_low_reg;
  logic [7:0]  rd_reg;
  logic        send_ack;

  logic [4:0]  phase_next;
  logic [2:0]  active_command_next;
  logic [3:0]  bit_counter_next;
  logic [15:0] delay_counter_next;
  logic [15:0] stretch_counter_next;
  logic [7:0]  shift_byte_next;
  logic        ack_flag_next;
  logic        scl_low_next;
  logic        sda_low_next;
  logic [7:0]  rd_reg_next;
  logic        send_ack_next;

  logic [4:0]      ph_eff;
  i2cm_pkg::uop_t  op;
  logic            do_act;
  logic            complete;
  logic            looping;
  logic            done;
  logic            timeout;
  logic            cmd_ok;

  assign cmd_ok = (item.cmd == i2cm_pkg::CMD_START) || (item.cmd == i2cm_pkg::CMD_STOP) ||
                  (item.cmd == i2cm_pkg::CMD_WRITE) || (item.cmd == i2cm_pkg::CMD_READ);

  always_comb begin
    active_command_next  = active_command;
    bit_counter_next     = bit_counter;
    delay_counter_next   = delay_counter;
    stretch_counter_next = stretch_counter;
    shift_byte_next      = shift_byte;
    ack_flag_next        = ack_flag;
    scl_low_next         = scl_low_reg;
    sda_low_next         = sda_low_reg;
    rd_reg_next          = rd_reg;
    send_ack_next        = send_ack;
    done                 = 1'b0;
    timeout              = 1'b0;
    do_act               = 1'b0;
    complete             = 1'b0;

    ph_eff = (phase > i2cm_pkg::LAST_PHASE) ? i2cm_pkg::PH_IDLE : phase;

    // command taken only while idle
    if (ph_eff == i2cm_pkg::PH_IDLE && cmd_ok) begin
      active_command_next  = item.cmd;
      bit_counter_next     = '0;
      delay_counter_next   = '0;
      stretch_counter_next = '0;
      shift_byte_next      = (item.cmd == i2cm_pkg::CMD_WRITE) ? item.wr_byte : 8'd0;
      if (item.cmd == i2cm_pkg::CMD_READ) begin
        send_ack_next = item.ack_to_send;
      end
      ph_eff = i2cm_pkg::cmd_entry(item.cmd);
    end

    op = i2cm_pkg::rom_op(ph_eff);

    if (ph_eff != i2cm_pkg::PH_IDLE) begin
      case (op.wkind)
        i2cm_pkg::W_NONE: begin
          do_act   = 1'b1;
          complete = 1'b1;
        end
        i2cm_pkg::W_DELAY: begin
          do_act = (delay_counter_next == 16'd0);
          if ({1'b0, delay_counter_next} + 17'd1 >= {1'b0, half_period}) begin
            delay_counter_next = '0;
            complete           = 1'b1;
          end else begin
            delay_counter_next = delay_counter_next + 16'd1;
          end
        end
        default: begin
          // clock stretch wait
          if (scl_low_next) begin
            scl_low_next = 1'b0;
          end else if (item.scl_in) begin
            stretch_counter_next = '0;
            complete             = 1'b1;
          end else if (stretch_counter_next >= stretch_limit) begin
            stretch_counter_next = '0;
            timeout              = 1'b1;
            complete             = 1'b1;
          end else begin
            stretch_counter_next = stretch_counter_next + 16'd1;
          end
        end
      endcase
    end

    if (do_act) begin
      case (op.act)
        i2cm_pkg::A_SDA_REL: sda_low_next = 1'b0;
        i2cm_pkg::A_SDA_LOW: sda_low_next = 1'b1;
        i2cm_pkg::A_SCL_LOW: scl_low_next = 1'b1;
        i2cm_pkg::A_SDA_BIT: sda_low_next = ~shift_byte_next[7];
        i2cm_pkg::A_SDA_ACK: sda_low_next = send_ack_next;
        i2cm_pkg::A_WR_NEXT: begin
          scl_low_next     = 1'b1;
          shift_byte_next  = {shift_byte_next[6:0], 1'b0};
          bit_counter_next = bit_counter_next + 4'd1;
        end
        i2cm_pkg::A_RD_NEXT: begin
          shift_byte_next  = {shift_byte_next[6:0], item.sda_in};
          scl_low_next     = 1'b1;
          bit_counter_next = bit_counter_next + 4'd1;
        end
        i2cm_pkg::A_ACK_SAMPLE: begin
          ack_flag_next = ~item.sda_in;
          scl_low_next  = 1'b1;
        end
        i2cm_pkg::A_RD_END: begin
          scl_low_next = 1'b1;
          sda_low_next = 1'b0;
        end
        default: ;
      endcase
    end

    looping    = (op.act == i2cm_pkg::A_WR_NEXT) || (op.act == i2cm_pkg::A_RD_NEXT);
    phase_next = ph_eff;
    if (complete) begin
      if (looping && bit_counter_next < i2cm_pkg::BITS_PER_BYTE) begin
        phase_next = op.loop_to;
      end else if (op.last) begin
        if (active_command_next == i2cm_pkg::CMD_READ) begin
          rd_reg_next = shift_byte_next;
        end
        phase_next          = i2cm_pkg::PH_IDLE;
        active_command_next = i2cm_pkg::CMD_NONE;
        done                = 1'b1;
      end else begin
        phase_next = ph_eff + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cm_pkg::PH_IDLE;
      active_command  <= i2cm_pkg::CMD_NONE;
      bit_counter     <= '0;
      delay_counter   <= '0;
      stretch_counter <= '0;
      shift_byte      <= '0;
      ack_flag        <= 1'b0;
      scl_low_reg     <= 1'b0;
      sda_low_reg     <= 1'b0;
      rd_reg          <= '0;
      send_ack        <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      active_command  <= active_command_next;
      bit_counter     <= bit_counter_next;
      delay_counter   <= delay_counter_next;
      stretch_counter <= stretch_counter_next;
      shift_byte      <= shift_byte_next;
      ack_flag        <= ack_flag_next;
      scl_low_reg     <= scl_low_next;
      sda_low_reg     <= sda_low_next;
      rd_reg          <= rd_reg_next;
      send_ack        <= send_ack_next;
    end
  end

  assign res.scl_drive_low   = scl_low_next;
  assign res.sda_drive_low   = sda_low_next;
  assign res.busy_res        = (phase_next != i2cm_pkg::PH_IDLE);
  assign res.done_res        = done;
  assign res.rd_byte         = rd_reg_next;
  assign res.ack_received    = ack_flag_next;
  assign res.stretch_timeout = timeout;

  // a completed command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && done |=> phase == i2cm_pkg::PH_IDLE)
    else $error("done without returning to idle");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= i2cm_pkg::LAST_PHASE)
    else $error("phase beyond sequence ROM");

  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
    step && phase == i2cm_pkg::PH_IDLE && !cmd_ok |=> phase == i2cm_pkg::PH_IDLE)
    else $error("unknown command left idle");

  a_timeout_wait: assert property (@(posedge clk) disable iff (rst)
    step && timeout |-> op.wkind == i2cm_pkg::W_SCL && !item.scl_in)
    else $error("stretch timeout outside an SCL wait");

  a_bits: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= i2cm_pkg::BITS_PER_BYTE)
    else $error("bit counter overran a byte");

endmodule

@@ src/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master stepped one tick per item: start, stop, byte write, byte read.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one tick per item: a command (taken only when
//   idle) plus the sampled SCL and SDA levels. Master stream (m_*) returns
//   exactly one result item per tick: the pin drives, busy/done, the last
//   read byte, the last ACK and a clock-stretch timeout pulse.
//   The cfg channel writes half_period (index 0) and stretch_limit (index 1);
//   other indexes are dropped. Write it only while no ticks are in flight.
//   Throughput is one item per cycle while the receiver takes results. An
//   item is held in the input register, the sequencer step runs between that
//   register and the result register, and the result is offered from there.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_tready drops only when both are occupied.
//   Reset clears both pipeline stages, releases both lines, returns the
//   sequencer to idle and loads half_period 100, stretch_limit 10000.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[2:0], wr_byte[10:3], ack_to_send[11], scl_in[12], sda_in[13], zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3],
  // rd_byte[11:4], ack_received[12], stretch_timeout[13], zero
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic            in_vld;
  i2cm_pkg::item_t in_q;
  logic            out_vld;
  i2cm_pkg::res_t  out_q;
  i2cm_pkg::res_t  res;
  logic            adv;
  logic [15:0]     half_period;
  logic [15:0]     stretch_limit;

  assign adv       = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= i2cm_pkg::HALF_PERIOD_RST;
      stretch_limit <= i2cm_pkg::STRETCH_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == i2cm_pkg::CFG_HALF_PERIOD) begin
        half_period <= cfg_data;
      end else if (cfg_index == i2cm_pkg::CFG_STRETCH_LIMIT) begin
        stretch_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= i2cm_pkg::item_t'(s_tdata[13:0]);
    end
  end

  i2cm_step u_step (
    .clk           (clk),
    .rst           (rst),
    .step          (adv),
    .item          (in_q),
    .half_period   (half_period),
    .stretch_limit (stretch_limit),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {2'b00, out_q};

endmodule

@@ verif/i2c_master_byte_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_test
// Tick-accurate check of the I2C master byte engine. A simple slave model
// answers the pin drives (with random clock stretching and bus noise) while
// an internal sequencer model predicts every result item. Commands run
// through several timing settings, including zero timing and the largest
// stretch limit.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_test;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [3:0] act;
    logic [1:0] wkind;
    logic       last;
    logic [4:0] loop_to;
  } seq_step_t;

  // Sequencer model plus the queue of result items it predicts.
  class i2c_line_board;
    logic [15:0] half_period = i2cm_pkg::HALF_PERIOD_RST;
    logic [15:0] stretch_limit = i2cm_pkg::STRETCH_LIMIT_RST;
    logic [4:0]  phase = i2cm_pkg::PH_IDLE;
    logic [2:0]  cur_cmd = i2cm_pkg::CMD_NONE;
    logic [3:0]  bit_cnt = '0;
    logic [15:0] dly_cnt = '0;
    logic [15:0] str_cnt = '0;
    logic [7:0]  shreg = '0;
    logic        ack_flag = 1'b0;
    logic        scl_low = 1'b0;
    logic        sda_low = 1'b0;
    logic [7:0]  rd_reg = '0;
    logic        ack_choice = 1'b0;
    i2cm_pkg::res_t line_results_q[$];
    int          n_items = 0;
    int          errors = 0;

    function void set_cfg(logic [1:0] idx, logic [15:0] val);
      if (idx == i2cm_pkg::CFG_HALF_PERIOD) half_period = val;
      else if (idx == i2cm_pkg::CFG_STRETCH_LIMIT) stretch_limit = val;
    endfunction

    function bit busy();
      return phase != i2cm_pkg::PH_IDLE;
    endfunction

    function int pending();
      return line_results_q.size();
    endfunction

    function logic [4:0] entry_of(logic [2:0] cmd);
      case (cmd)
        i2cm_pkg::CMD_START: return i2cm_pkg::PH_START;
        i2cm_pkg::CMD_STOP:  return i2cm_pkg::PH_STOP;
        i2cm_pkg::CMD_WRITE: return i2cm_pkg::PH_WRITE;
        i2cm_pkg::CMD_READ:  return i2cm_pkg::PH_READ;
        default:             return i2cm_pkg::PH_IDLE;
      endcase
    endfunction

    function seq_step_t step_at(logic [4:0] ph);
      case (ph)
        i2cm_pkg::PH_START:
          return '{i2cm_pkg::A_SDA_REL, i2cm_pkg::W_NONE, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_START + 5'd1:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_SCL, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_START + 5'd2:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_START + 5'd3:
          return '{i2cm_pkg::A_SDA_LOW, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_START + 5'd4:
          return '{i2cm_pkg::A_SCL_LOW, i2cm_pkg::W_DELAY, 1'b1, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_STOP:
          return '{i2cm_pkg::A_SCL_LOW, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_STOP + 5'd1:
          return '{i2cm_pkg::A_SDA_LOW, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_STOP + 5'd2:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_SCL, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_STOP + 5'd3:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_STOP + 5'd4:
          return '{i2cm_pkg::A_SDA_REL, i2cm_pkg::W_DELAY, 1'b1, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE:
          return '{i2cm_pkg::A_SDA_BIT, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE + 5'd1:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_SCL, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE + 5'd2:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE + 5'd3:
          return '{i2cm_pkg::A_WR_NEXT, i2cm_pkg::W_NONE, 1'b0, i2cm_pkg::PH_WR_LOOP};
        i2cm_pkg::PH_WRITE + 5'd4:
          return '{i2cm_pkg::A_SDA_REL, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE + 5'd5:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_SCL, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE + 5'd6:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_WRITE + 5'd7:
          return '{i2cm_pkg::A_ACK_SAMPLE, i2cm_pkg::W_DELAY, 1'b1, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ:
          return '{i2cm_pkg::A_SDA_REL, i2cm_pkg::W_NONE, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd1:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd2:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_SCL, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd3:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd4:
          return '{i2cm_pkg::A_RD_NEXT, i2cm_pkg::W_NONE, 1'b0, i2cm_pkg::PH_RD_LOOP};
        i2cm_pkg::PH_READ + 5'd5:
          return '{i2cm_pkg::A_SDA_ACK, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd6:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_SCL, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd7:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_DELAY, 1'b0, i2cm_pkg::PH_IDLE};
        i2cm_pkg::PH_READ + 5'd8:
          return '{i2cm_pkg::A_RD_END, i2cm_pkg::W_NONE, 1'b1, i2cm_pkg::PH_IDLE};
        default:
          return '{i2cm_pkg::A_NOP, i2cm_pkg::W_NONE, 1'b1, i2cm_pkg::PH_IDLE};
      endcase
    endfunction

    function void apply(logic [3:0] act, logic sda);
      case (act)
        i2cm_pkg::A_SDA_REL: sda_low = 1'b0;
        i2cm_pkg::A_SDA_LOW: sda_low = 1'b1;
        i2cm_pkg::A_SCL_LOW: scl_low = 1'b1;
        i2cm_pkg::A_SDA_BIT: sda_low = ~shreg[7];
        i2cm_pkg::A_SDA_ACK: sda_low = ack_choice;
        i2cm_pkg::A_WR_NEXT: begin
          scl_low = 1'b1;
          shreg = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
        end
        i2cm_pkg::A_RD_NEXT: begin
          shreg = {shreg[6:0], sda};
          scl_low = 1'b1;
          bit_cnt = bit_cnt + 4'd1;
        end
        i2cm_pkg::A_ACK_SAMPLE: begin
          ack_flag = ~sda;
          scl_low = 1'b1;
        end
        i2cm_pkg::A_RD_END: begin
          scl_low = 1'b1;
          sda_low = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // one tick of the sequencer; queues the result item it produces
    function void note_item(i2cm_pkg::item_t it);
      seq_step_t      st;
      i2cm_pkg::res_t r;
      logic           fin;
      logic           done;
      logic           tmo;
      fin = 1'b0;
      done = 1'b0;
      tmo = 1'b0;
      n_items++;
      if (phase > i2cm_pkg::LAST_PHASE) phase = i2cm_pkg::PH_IDLE;
      if (phase == i2cm_pkg::PH_IDLE && it.cmd >= i2cm_pkg::CMD_START &&
          it.cmd <= i2cm_pkg::CMD_READ) begin
        cur_cmd = it.cmd;
        bit_cnt = '0;
        dly_cnt = '0;
        str_cnt = '0;
        shreg = (it.cmd == i2cm_pkg::CMD_WRITE) ? it.wr_byte : 8'h00;
        if (it.cmd == i2cm_pkg::CMD_READ) ack_choice = it.ack_to_send;
        phase = entry_of(it.cmd);
      end
      if (phase != i2cm_pkg::PH_IDLE) begin
        st = step_at(phase);
        case (st.wkind)
          i2cm_pkg::W_NONE: begin
            apply(st.act, it.sda_in);
            fin = 1'b1;
          end
          i2cm_pkg::W_DELAY: begin
            // pin change lands on the first tick of the delay
            if (dly_cnt == 16'd0) apply(st.act, it.sda_in);
            if ({1'b0, dly_cnt} + 17'd1 >= {1'b0, half_period}) begin
              dly_cnt = '0;
              fin = 1'b1;
            end else begin
              dly_cnt = dly_cnt + 16'd1;
            end
          end
          default: begin
            if (scl_low) begin
              scl_low = 1'b0;
            end else if (it.scl_in) begin
              str_cnt = '0;
              fin = 1'b1;
            end else if (str_cnt >= stretch_limit) begin
              str_cnt = '0;
              tmo = 1'b1;
              fin = 1'b1;
            end else begin
              str_cnt = str_cnt + 16'd1;
            end
          end
        endcase
        if (fin) begin
          if ((st.act == i2cm_pkg::A_WR_NEXT || st.act == i2cm_pkg::A_RD_NEXT) &&
              bit_cnt < i2cm_pkg::BITS_PER_BYTE) begin
            phase = st.loop_to;
          end else if (st.last) begin
            if (cur_cmd == i2cm_pkg::CMD_READ) rd_reg = shreg;
            phase = i2cm_pkg::PH_IDLE;
            cur_cmd = i2cm_pkg::CMD_NONE;
            done = 1'b1;
          end else begin
            phase = phase + 5'd1;
          end
        end
      end
      r.scl_drive_low = scl_low;
      r.sda_drive_low = sda_low;
      r.busy_res = (phase != i2cm_pkg::PH_IDLE);
      r.done_res = done;
      r.rd_byte = rd_reg;
      r.ack_received = ack_flag;
      r.stretch_timeout = tmo;
      line_results_q.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [15:0] bus);
      i2cm_pkg::res_t got;
      i2cm_pkg::res_t want;
      got = bus[13:0];
      if (line_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %h with nothing expected", $time, bus);
        return;
      end
      want = line_results_q.pop_front();
      cmp("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
      cmp("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
      cmp("busy_res", want.busy_res, got.busy_res);
      cmp("done_res", want.done_res, got.done_res);
      cmp("rd_byte", want.rd_byte, got.rd_byte);
      cmp("ack_received", want.ack_received, got.ack_received);
      cmp("stretch_timeout", want.stretch_timeout, got.stretch_timeout);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  i2c_line_board sb = new();

  int send_idle = 0;
  int recv_idle = 0;
  int stretch_pct = 0;
  int noise_pct = 0;
  int slave_hold = 0;
  int hold_cnt = 0;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  i2c_master_byte_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: checks every accepted item, stalls at random or on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One tick: the slave answers the predicted pin drives, with optional
  // clock stretching and random bus noise.
  task automatic tick(input logic [2:0] cmd, input logic [7:0] wr, input logic ack);
    i2cm_pkg::item_t it;
    if (slave_hold == 0 && $urandom_range(0, 99) < stretch_pct)
      slave_hold = $urandom_range(1, 6);
    it.cmd = cmd;
    it.wr_byte = wr;
    it.ack_to_send = ack;
    if (slave_hold > 0) begin
      it.scl_in = 1'b0;
      slave_hold--;
    end else begin
      it.scl_in = ~sb.scl_low;
    end
    it.sda_in = sb.sda_low ? 1'b0 : 1'($urandom);
    if ($urandom_range(0, 99) < noise_pct) begin
      it.scl_in = 1'($urandom);
      it.sda_in = 1'($urandom);
    end
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, it};
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
  endtask

  // issue a command, then tick until the sequence finishes; stray commands
  // land while busy now and then
  task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] wr, input logic ack);
    tick(cmd, wr, ack);
    while (sb.busy())
      tick(($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : i2cm_pkg::CMD_NONE,
           8'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_cfg(idx, val);
  endtask

  task automatic random_traffic(input int n);
    int target;
    int nw;
    int nr;
    int pick;
    target = sb.n_items + n;
    while (sb.n_items < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // well-formed transfer: address/data writes, optional repeated start
        // and reads ending in NACK, then stop
        run_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom));
        nw = $urandom_range(1, 3);
        repeat (nw) run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 1)) begin
          run_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom));
          run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom));
          nr = $urandom_range(1, 3);
          for (int i = 0; i < nr; i++)
            run_cmd(i2cm_pkg::CMD_READ, 8'($urandom), (i < nr - 1));
        end
        run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom));
      end else if (pick < 9) begin
        run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) tick(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= i2cm_pkg::CFG_HALF_PERIOD;
    cfg_data <= '0;
    m_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset timing values
    run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0);

    // directed part
    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd2);
    write_reg(i2cm_pkg::CFG_STRETCH_LIMIT, 16'd3);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0);
    run_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0);
    run_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1);
    slave_hold = 2;  // short stretch, released before the limit
    run_cmd(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0);
    run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
    run_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b0);
    run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    for (int c = i2cm_pkg::CMD_READ + 1; c < 8; c++) run_cmd(3'(c), 8'h5A, 1'b1);
    run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    slave_hold = 12;  // slave holds SCL past the limit
    run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0);
    run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
    run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);

    // zero half period and zero stretch limit, receiver mostly stalled
    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd0);
    write_reg(i2cm_pkg::CFG_STRETCH_LIMIT, 16'd0);
    send_idle = 10;
    recv_idle = 76;
    stretch_pct = 5;
    noise_pct = 3;
    hold_req = 1'b1;
    random_traffic(200);

    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd1);
    write_reg(i2cm_pkg::CFG_STRETCH_LIMIT, 16'd4);
    send_idle = 76;
    recv_idle = 10;
    random_traffic(80);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    random_traffic(80);

    write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd3);
    write_reg(i2cm_pkg::CFG_STRETCH_LIMIT, 16'hFFFF);
    send_idle = 0;
    recv_idle = 0;
    random_traffic(200);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
src/i2cm_pkg.sv
src/i2cm_step.sv
src/i2c_master_byte_engine.sv
verif/i2c_master_byte_engine_test.sv
